[sv/ajrb_pkg.sv]
// ajrb_pkg: shared types and codes of the audio jitter reorder buffer
// no dependencies; imported by every module of the block

package ajrb_pkg;

   localparam int INDEX_W  = 32;
   localparam int TIME_W   = 48;
   localparam int HANDLE_W = 32;
   localparam int LEN_W    = 16;
   localparam int COUNT_W  = 32;
   localparam int DELAY_W  = 24;   // target delay in microseconds, max 16383 * 1000
   localparam int CSR_W    = 14;
   localparam int STATUS_W = 3;

   localparam int REQ_DATA_W = INDEX_W + TIME_W + HANDLE_W + LEN_W + TIME_W;
   localparam int RSP_DATA_W = INDEX_W + TIME_W + HANDLE_W + LEN_W + 5 * COUNT_W;

   localparam int US_PER_MS = 1000;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_LATE      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FRAME     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_CONCEAL   = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_NONE      = 3'd6;

   // one descriptor slot as held in the slot memory
   typedef struct packed {
      logic                valid;
      logic [INDEX_W-1:0]  index;
      logic [TIME_W-1:0]   timestamp;
      logic [TIME_W-1:0]   arrival;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    length;
   } slot_type;

   // counter increments of one item
   typedef struct packed {
      logic pushed;
      logic late;
      logic duplicate;
      logic emitted;
      logic concealed;
   } stat_inc_type;

   typedef struct packed {
      logic [COUNT_W-1:0] pushed;
      logic [COUNT_W-1:0] late;
      logic [COUNT_W-1:0] duplicate;
      logic [COUNT_W-1:0] emitted;
      logic [COUNT_W-1:0] concealed;
   } stat_cnt_type;

endpackage

[sv/ajrb_slot_ram.sv]
// ajrb_slot_ram: descriptor slot memory, one write and one registered read port
// depends on ajrb_pkg for the slot layout

module ajrb_slot_ram
   import ajrb_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  slot_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output slot_type      rd_data
);

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ajrb_stats.sv]
// ajrb_stats: wrapping statistics counters of the jitter buffer
// depends on ajrb_pkg for the counter structs

module ajrb_stats
   import ajrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  stat_inc_type inc,
   output stat_cnt_type cnt_next
);

   stat_cnt_type cnt_ff;

   always_comb begin
      cnt_next.pushed    = cnt_ff.pushed    + COUNT_W'(inc.pushed);
      cnt_next.late      = cnt_ff.late      + COUNT_W'(inc.late);
      cnt_next.duplicate = cnt_ff.duplicate + COUNT_W'(inc.duplicate);
      cnt_next.emitted   = cnt_ff.emitted   + COUNT_W'(inc.emitted);
      cnt_next.concealed = cnt_ff.concealed + COUNT_W'(inc.concealed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (en) begin
         cnt_ff <= cnt_next;
      end
   end

endmodule

[sv/audio_jitter_reorder_buffer.sv]
// audio_jitter_reorder_buffer: top level, command sequencer and result register
// depends on ajrb_pkg, ajrb_slot_ram and ajrb_stats

// Reorders audio frame descriptors by frame index and releases them once the
// head frame has aged by the target delay. Descriptors sit in a DEPTH-entry
// slot memory with a registered read port; each push or pop (but a late push,
// which needs no walk) walks the whole memory once, one slot per cycle, to find
// a duplicate and the first free slot or the head (smallest index). The walk is
// paced by the single read port of the slot memory. After reset a clearing pass
// marks every slot empty; no word is accepted during it, configuration writes
// are taken as ever. The result register lets the next word be taken while a
// result still waits on the response side. The target delay register is only to
// be written while the block is idle.

module audio_jitter_reorder_buffer
   import ajrb_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // fields from bit 0: sequence index, timestamp, payload_handle, payload_len, now_us
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // fields from bit 0: cmd
   input  logic                  req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // fields from bit 0: emitted sequence index, out_timestamp, out_payload_handle,
   // out_payload_len, count_pushed, count_late, count_duplicate,
   // count_emitted, count_concealed
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // fields from bit 0: status
   output logic [STATUS_W-1:0]   rsp_tuser,
   // target delay register, milliseconds
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_W-1:0]      csr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   // sequencer states
   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   // request word split into fields
   logic [INDEX_W-1:0]  req_index;
   logic [TIME_W-1:0]   req_ts;
   logic [HANDLE_W-1:0] req_handle;
   logic [LEN_W-1:0]    req_len;
   logic [TIME_W-1:0]   req_now;

   assign {req_now, req_len, req_handle, req_ts, req_index} = req_tdata;

   // control state
   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      scan_addr_ff, scan_addr_in;
   logic               issuing_ff, issuing_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [AW-1:0]      chk_addr_ff;
   logic               late_ff, late_in;
   logic               dup_ff, dup_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      hit_addr_ff, hit_addr_in;
   logic [INDEX_W-1:0] expected_ff, expected_in;
   logic               started_ff, started_in;
   logic [DELAY_W-1:0] delay_us_ff, delay_us_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // latched request word and head candidate
   logic                cmd_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [TIME_W-1:0]   ts_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [TIME_W-1:0]   now_ff;
   slot_type            head_ff, head_in;

   // result register
   logic [STATUS_W-1:0] rsp_status_ff, res_status;
   logic [INDEX_W-1:0]  rsp_index_ff, res_index;
   logic [TIME_W-1:0]   rsp_ts_ff, res_ts;
   logic [HANDLE_W-1:0] rsp_handle_ff, res_handle;
   logic [LEN_W-1:0]    rsp_len_ff, res_len;
   stat_cnt_type        rsp_cnt_ff;

   // memory and counter hookup
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr;
   slot_type      wr_data, rd_data;
   stat_inc_type  inc;
   stat_cnt_type  cnt_next;

   logic               req_accept, out_free, commit;
   logic [INDEX_W-1:0] exp_eff;
   logic [TIME_W-1:0]  age;
   logic               too_young;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign commit     = (state_ff == S_FINISH) & out_free;
   assign csr_ready  = 1'b1;

   // the first pop takes the head index as the expected one
   assign exp_eff   = started_ff ? expected_ff : head_ff.index;
   assign age       = now_ff - head_ff.arrival;
   assign too_young = age < TIME_W'(delay_us_ff);

   assign delay_us_in = (csr_valid & csr_ready)
                        ? DELAY_W'(csr_data) * DELAY_W'(US_PER_MS) : delay_us_ff;

   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      issuing_in   = issuing_ff;
      chk_vld_in   = 1'b0;
      late_in      = late_ff;
      dup_in       = dup_ff;
      found_in     = found_ff;
      hit_addr_in  = hit_addr_ff;
      head_in      = head_ff;
      expected_in  = expected_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = hit_addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      inc          = '0;
      res_status   = STATUS_NONE;
      res_index    = '0;
      res_ts       = '0;
      res_handle   = '0;
      res_len      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // clearing pass: mark one slot empty per cycle
            wr_en   = 1'b1;
            wr_addr = scan_addr_ff;
            if (scan_addr_ff == LAST_ADDR) begin
               scan_addr_in = '0;
               state_in     = S_IDLE;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               late_in      = (req_tuser == CMD_PUSH) & started_ff
                              & (req_index < expected_ff);
               dup_in       = 1'b0;
               found_in     = 1'b0;
               scan_addr_in = '0;
               if (late_in) begin
                  state_in = S_FINISH;
               end else begin
                  issuing_in = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // each slot is checked in the cycle after its read is issued
            rd_en      = issuing_ff;
            chk_vld_in = issuing_ff;
            if (issuing_ff) begin
               if (scan_addr_ff == LAST_ADDR) begin
                  issuing_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (chk_vld_ff) begin
               if (cmd_ff == CMD_PUSH) begin
                  if (rd_data.valid && rd_data.index == index_ff) begin
                     dup_in = 1'b1;
                  end
                  if (!rd_data.valid && !found_ff) begin
                     found_in    = 1'b1;
                     hit_addr_in = chk_addr_ff;
                  end
               end else begin
                  if (rd_data.valid && (!found_ff || rd_data.index < head_ff.index)) begin
                     found_in    = 1'b1;
                     hit_addr_in = chk_addr_ff;
                     head_in     = rd_data;
                  end
               end
            end
            if (!issuing_ff && !chk_vld_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // outside the clearing pass, memory writes land here only; the next walk starts
            // only after a pass through S_IDLE, so no read can meet a pending write
            if (cmd_ff == CMD_PUSH) begin
               inc.pushed = 1'b1;
               if (late_ff) begin
                  res_status = STATUS_LATE;
                  inc.late   = 1'b1;
               end else if (dup_ff) begin
                  res_status    = STATUS_DUPLICATE;
                  inc.duplicate = 1'b1;
               end else if (!found_ff) begin
                  res_status = STATUS_FULL;
               end else begin
                  res_status        = STATUS_ACCEPTED;
                  wr_en             = out_free;
                  wr_data.valid     = 1'b1;
                  wr_data.index     = index_ff;
                  wr_data.timestamp = ts_ff;
                  wr_data.arrival   = now_ff;
                  wr_data.handle    = handle_ff;
                  wr_data.length    = len_ff;
               end
            end else if (found_ff) begin
               if (out_free) begin
                  started_in  = 1'b1;
                  expected_in = exp_eff;
               end
               if (too_young) begin
                  res_status = STATUS_NONE;
               end else if (head_ff.index == exp_eff) begin
                  res_status    = STATUS_FRAME;
                  res_index     = head_ff.index;
                  res_ts        = head_ff.timestamp;
                  res_handle    = head_ff.handle;
                  res_len       = head_ff.length;
                  inc.emitted   = 1'b1;
                  wr_en         = out_free;
                  wr_data       = head_ff;
                  wr_data.valid = 1'b0;
                  if (out_free) begin
                     expected_in = head_ff.index + 1'b1;
                  end
               end else begin
                  res_status    = STATUS_CONCEAL;
                  res_index     = exp_eff;
                  inc.concealed = 1'b1;
                  if (out_free) begin
                     expected_in = exp_eff + 1'b1;
                  end
               end
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_addr_ff <= '0;
         issuing_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
         late_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         found_ff     <= 1'b0;
         expected_ff  <= '0;
         started_ff   <= 1'b0;
         delay_us_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_addr_ff <= scan_addr_in;
         issuing_ff   <= issuing_in;
         chk_vld_ff   <= chk_vld_in;
         late_ff      <= late_in;
         dup_ff       <= dup_in;
         found_ff     <= found_in;
         expected_ff  <= expected_in;
         started_ff   <= started_in;
         delay_us_ff  <= delay_us_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      chk_addr_ff <= scan_addr_ff;
      hit_addr_ff <= hit_addr_in;
      head_ff     <= head_in;
      if (req_accept) begin
         cmd_ff    <= req_tuser;
         index_ff  <= req_index;
         ts_ff     <= req_ts;
         handle_ff <= req_handle;
         len_ff    <= req_len;
         now_ff    <= req_now;
      end
      if (commit) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_index;
         rsp_ts_ff     <= res_ts;
         rsp_handle_ff <= res_handle;
         rsp_len_ff    <= res_len;
         rsp_cnt_ff    <= cnt_next;
      end
   end

   ajrb_slot_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   ajrb_stats u_stats (
      .clock    (clock),
      .reset    (reset),
      .en       (commit),
      .inc      (inc),
      .cnt_next (cnt_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_cnt_ff.concealed, rsp_cnt_ff.emitted, rsp_cnt_ff.duplicate,
                        rsp_cnt_ff.late, rsp_cnt_ff.pushed, rsp_len_ff, rsp_handle_ff,
                        rsp_ts_ff, rsp_index_ff};

endmodule
